FILE: hdl/vna_pkg.sv
// Shared types and constants of the vertex normal accumulator.
// No dependencies; every module of the block imports this package.
package vna_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = 11;
   localparam int POS_W        = 32;
   localparam int SUM_W        = 24;
   localparam int NRM_W        = 16;
   localparam int VEC_W        = 34;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;

   localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(1024);
   localparam logic [CNT_W-1:0] MAX_CNT      = CNT_W'(MAX_VERTICES);

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TRI  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_DEGEN = 2'd2;

   typedef enum logic [2:0] {
      K_LOAD = 3'd0,
      K_TRI  = 3'd1,
      K_READ = 3'd2,
      K_NOP  = 3'd3,
      K_BAD  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0]              operation;
      logic [IDX_W-1:0]        index_a;
      logic [IDX_W-1:0]        index_b;
      logic [IDX_W-1:0]        index_c;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
   } rsp_type;

   typedef struct packed {
      kind_type                kind;
      logic [IDX_W-1:0]        index_a;
      logic [IDX_W-1:0]        index_b;
      logic [IDX_W-1:0]        index_c;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } cmd_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
   } vec3_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] x;
      logic signed [NRM_W-1:0] y;
      logic signed [NRM_W-1:0] z;
   } nrm3_type;

endpackage

FILE: hdl/vertex_normal_accumulator.sv
// Vertex normal accumulator: smooth per-vertex normals from averaged face normals.
// Input channel req_* takes load, triangle and read items; each gives one rsp_* item
// with a status and, for a good read, the Q1.14 unit normal of the vertex sum.
// csr_wr_en/csr_wr_data set the vertex count; write it only while the block is idle.
// After reset the block clears all 1024 normal sums, one per cycle, and holds
// req_ready low until the clear is done.
// Items run one at a time in the back end; a two-entry queue lets the input side
// keep accepting while the back end works or a result waits.
// Reads and triangles use the shared normalizer (scale, three squares, 32-step
// square root, 15-step division); load, bad index and unused code do not.
// A triangle puts three vectors through the normalizer, plus cross product
// and three read-modify-writes of the sums; a degenerate one stops early.
// When rsp_ready is low the finished item holds in the output register; the back
// end waits on it, and once the queue is full req_ready drops.
module vertex_normal_accumulator import vna_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   logic    init_done;
   logic    q_ready, q_push, q_pop, q_valid;
   cmd_type q_cmd, q_head;

   vna_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .init_done   (init_done),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   vna_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cmd),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   vna_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .init_done (init_done),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/vna_front.sv
// Front end: holds the vertex count register, range-checks and classifies items.
// Depends on vna_pkg; feeds vna_queue.
module vna_front import vna_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic             init_done,
   input  logic             q_ready,
   output logic             q_push,
   output cmd_type          q_cmd
);

   logic [CNT_W-1:0] vcount_ff;
   logic [CNT_W-1:0] limit;
   logic             a_ok, b_ok, c_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   assign limit = (vcount_ff > MAX_CNT) ? MAX_CNT : vcount_ff;
   assign a_ok  = {1'b0, req_data.index_a} < limit;
   assign b_ok  = {1'b0, req_data.index_b} < limit;
   assign c_ok  = {1'b0, req_data.index_c} < limit;

   assign req_ready = q_ready & init_done;
   assign q_push    = req_valid & req_ready;

   always_comb begin
      q_cmd.index_a = req_data.index_a;
      q_cmd.index_b = req_data.index_b;
      q_cmd.index_c = req_data.index_c;
      q_cmd.pos_x   = req_data.pos_x;
      q_cmd.pos_y   = req_data.pos_y;
      q_cmd.pos_z   = req_data.pos_z;
      unique case (req_data.operation)
         OP_LOAD: q_cmd.kind = a_ok ? K_LOAD : K_BAD;
         OP_TRI:  q_cmd.kind = (a_ok && b_ok && c_ok) ? K_TRI : K_BAD;
         OP_READ: q_cmd.kind = a_ok ? K_READ : K_BAD;
         default: q_cmd.kind = K_NOP;
      endcase
   end

endmodule

FILE: hdl/vna_queue.sv
// Short command queue between the front end and the back end.
// Depends on vna_pkg for the command type and depth.
module vna_queue import vna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    ready,
   input  logic    pop,
   output logic    valid,
   output cmd_type head
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hdl/vna_norm.sv
// Iterative vector normalizer: scale, sum of squares, bit-serial square root and
// three parallel restoring dividers giving a Q1.14 unit vector. Depends on vna_pkg.
module vna_norm import vna_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  vec3_type vec,
   output logic     done,
   output logic     ok,
   output nrm3_type nrm
);

   typedef enum logic [5:0] {
      N_IDLE  = 6'b000001,
      N_SHIFT = 6'b000010,
      N_SQ    = 6'b000100,
      N_ROOT  = 6'b001000,
      N_PREP  = 6'b010000,
      N_DIV   = 6'b100000
   } nstate_type;

   nstate_type        state_ff;
   logic [VEC_W-1:0]  m0_ff, m1_ff, m2_ff;
   logic [2:0]        neg_ff;
   logic [3:0]        cnt_ff;
   logic [61:0]       sq_ff;
   logic [63:0]       rv_ff, rr_ff, rb_ff;
   logic [45:0]       dv_ff, rem0_ff, rem1_ff, rem2_ff;
   logic [14:0]       q0_ff, q1_ff, q2_ff;
   logic              done_ff, ok_ff;

   logic [VEC_W-1:0]  big;
   logic [29:0]       msel;
   logic [59:0]       prod;
   logic [61:0]       sq_in;
   logic [63:0]       trial;
   logic [31:0]       len;

   function automatic logic [VEC_W-1:0] mag(input logic signed [VEC_W-1:0] v);
      mag = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
   endfunction

   function automatic logic signed [NRM_W-1:0] apply_sign(input logic n,
                                                          input logic [14:0] q);
      logic signed [NRM_W-1:0] s;
      s = NRM_W'(q);
      apply_sign = n ? -s : s;
   endfunction

   always_comb begin
      big = m0_ff;
      if (m1_ff > big) big = m1_ff;
      if (m2_ff > big) big = m2_ff;
      case (cnt_ff)
         4'd0:    msel = m0_ff[29:0];
         4'd1:    msel = m1_ff[29:0];
         default: msel = m2_ff[29:0];
      endcase
      prod  = msel * msel;
      sq_in = sq_ff + 62'(prod);
      trial = rr_ff + rb_ff;
      len   = rr_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         // pulse done on a zero vector or after the last quotient bit
         done_ff <= (state_ff == N_SHIFT && big == '0) ||
                    (state_ff == N_DIV && cnt_ff == 4'd0);
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  state_ff <= N_SHIFT;
                  ok_ff    <= 1'b1;
               end
            end
            N_SHIFT: begin
               if (big == '0) begin
                  ok_ff    <= 1'b0;
                  state_ff <= N_IDLE;
               end else if (big[VEC_W-1:26] >= (VEC_W-26)'(16)) begin
                  state_ff <= N_SHIFT;
               end else if (big[VEC_W-1:26] == '0 || big[VEC_W-1:29] == '0) begin
                  state_ff <= N_SHIFT;
               end else begin
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               if (cnt_ff == 4'd2) state_ff <= N_ROOT;
            end
            N_ROOT: begin
               if (rb_ff == 64'd1) state_ff <= N_PREP;
            end
            N_PREP: begin
               state_ff <= N_DIV;
            end
            N_DIV: begin
               if (cnt_ff == 4'd0) begin
                  state_ff <= N_IDLE;
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         N_IDLE: begin
            m0_ff  <= mag(vec.x);
            m1_ff  <= mag(vec.y);
            m2_ff  <= mag(vec.z);
            neg_ff <= {vec.z[VEC_W-1], vec.y[VEC_W-1], vec.x[VEC_W-1]};
            cnt_ff <= 4'd0;
            sq_ff  <= '0;
         end
         N_SHIFT: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (big[VEC_W-1:30] != '0) begin
               m0_ff <= m0_ff >> 1;
               m1_ff <= m1_ff >> 1;
               m2_ff <= m2_ff >> 1;
            end else if (big[VEC_W-1:26] == '0) begin
               m0_ff <= m0_ff << 4;
               m1_ff <= m1_ff << 4;
               m2_ff <= m2_ff << 4;
            end else if (big[VEC_W-1:29] == '0) begin
               m0_ff <= m0_ff << 1;
               m1_ff <= m1_ff << 1;
               m2_ff <= m2_ff << 1;
            end
            cnt_ff <= 4'd0;
            sq_ff  <= '0;
         end
         N_SQ: begin
            sq_ff  <= sq_in;
            cnt_ff <= cnt_ff + 4'd1;
            rv_ff  <= 64'(sq_in);
            rr_ff  <= '0;
            rb_ff  <= 64'h4000_0000_0000_0000;
         end
         N_ROOT: begin
            if (rv_ff >= trial) begin
               rv_ff <= rv_ff - trial;
               rr_ff <= (rr_ff >> 1) + rb_ff;
            end else begin
               rr_ff <= rr_ff >> 1;
            end
            rb_ff <= rb_ff >> 2;
         end
         N_PREP: begin
            dv_ff   <= {len, 14'd0};
            rem0_ff <= 46'({m0_ff[29:0], 14'd0}) + 46'(len >> 1);
            rem1_ff <= 46'({m1_ff[29:0], 14'd0}) + 46'(len >> 1);
            rem2_ff <= 46'({m2_ff[29:0], 14'd0}) + 46'(len >> 1);
            q0_ff   <= '0;
            q1_ff   <= '0;
            q2_ff   <= '0;
            cnt_ff  <= 4'd14;
         end
         N_DIV: begin
            if (rem0_ff >= dv_ff) begin
               rem0_ff <= rem0_ff - dv_ff;
               q0_ff   <= {q0_ff[13:0], 1'b1};
            end else begin
               q0_ff   <= {q0_ff[13:0], 1'b0};
            end
            if (rem1_ff >= dv_ff) begin
               rem1_ff <= rem1_ff - dv_ff;
               q1_ff   <= {q1_ff[13:0], 1'b1};
            end else begin
               q1_ff   <= {q1_ff[13:0], 1'b0};
            end
            if (rem2_ff >= dv_ff) begin
               rem2_ff <= rem2_ff - dv_ff;
               q2_ff   <= {q2_ff[13:0], 1'b1};
            end else begin
               q2_ff   <= {q2_ff[13:0], 1'b0};
            end
            dv_ff  <= dv_ff >> 1;
            cnt_ff <= cnt_ff - 4'd1;
         end
         default: begin
            cnt_ff <= 4'd0;
         end
      endcase
   end

   assign done  = done_ff;
   assign ok    = ok_ff;
   assign nrm.x = apply_sign(neg_ff[0], q0_ff);
   assign nrm.y = apply_sign(neg_ff[1], q1_ff);
   assign nrm.z = apply_sign(neg_ff[2], q2_ff);

endmodule

FILE: hdl/vna_back.sv
// Back end: vertex and sum memories, the item sequencer, cross product and
// result register. Depends on vna_pkg and vna_norm.
module vna_back import vna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    init_done,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [18:0] {
      S_CLEAR = 19'h00001,
      S_IDLE  = 19'h00002,
      S_LOAD  = 19'h00004,
      S_RSUM  = 19'h00008,
      S_RWAIT = 19'h00010,
      S_RNORM = 19'h00020,
      S_VA    = 19'h00040,
      S_VB    = 19'h00080,
      S_VC    = 19'h00100,
      S_VD    = 19'h00200,
      S_E1    = 19'h00400,
      S_W1    = 19'h00800,
      S_W2    = 19'h01000,
      S_CR    = 19'h02000,
      S_CRN   = 19'h04000,
      S_W3    = 19'h08000,
      S_SA    = 19'h10000,
      S_SB    = 19'h20000,
      S_DONE  = 19'h40000
   } bstate_type;

   bstate_type              state_ff;
   cmd_type                 cmd_ff;
   logic [IDX_W-1:0]        clr_ff;
   logic [1:0]              k_ff;
   logic [2:0]              step_ff;
   rsp_type                 res_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   logic signed [POS_W-1:0] vx_mem [MAX_VERTICES];
   logic signed [POS_W-1:0] vy_mem [MAX_VERTICES];
   logic signed [POS_W-1:0] vz_mem [MAX_VERTICES];
   logic signed [SUM_W-1:0] sx_mem [MAX_VERTICES];
   logic signed [SUM_W-1:0] sy_mem [MAX_VERTICES];
   logic signed [SUM_W-1:0] sz_mem [MAX_VERTICES];

   logic signed [POS_W-1:0] vx_rd_ff, vy_rd_ff, vz_rd_ff;
   logic signed [SUM_W-1:0] sx_rd_ff, sy_rd_ff, sz_rd_ff;
   logic signed [POS_W-1:0] pax_ff, pay_ff, paz_ff;
   logic signed [POS_W-1:0] pbx_ff, pby_ff, pbz_ff;
   logic signed [POS_W-1:0] pcx_ff, pcy_ff, pcz_ff;
   nrm3_type                n1_ff, n2_ff, fn_ff;
   logic signed [31:0]      prod_ff;
   vec3_type                cr_ff;

   logic                    vtx_we, sum_we;
   logic [IDX_W-1:0]        vtx_addr, sum_addr;
   logic signed [SUM_W-1:0] sum_wx, sum_wy, sum_wz;
   logic [IDX_W-1:0]        corner;
   logic                    norm_start, norm_done, norm_ok;
   vec3_type                norm_vec;
   nrm3_type                norm_nrm;
   logic signed [NRM_W-1:0] mul_a, mul_b;
   logic signed [31:0]      prod;
   logic signed [VEC_W-1:0] cr_diff;
   logic                    out_free;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [NRM_W-1:0] a);
      logic signed [SUM_W:0] t;
      t = (SUM_W+1)'(s) + (SUM_W+1)'(a);
      if (t > (SUM_W+1)'(8388607)) begin
         sat_add = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (t < -(SUM_W+1)'(8388608)) begin
         sat_add = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sat_add = t[SUM_W-1:0];
      end
   endfunction

   vna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec   (norm_vec),
      .done  (norm_done),
      .ok    (norm_ok),
      .nrm   (norm_nrm)
   );

   // memories: one address per group, registered read
   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vx_mem[vtx_addr] <= cmd_ff.pos_x;
         vy_mem[vtx_addr] <= cmd_ff.pos_y;
         vz_mem[vtx_addr] <= cmd_ff.pos_z;
      end
      vx_rd_ff <= vx_mem[vtx_addr];
      vy_rd_ff <= vy_mem[vtx_addr];
      vz_rd_ff <= vz_mem[vtx_addr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sx_mem[sum_addr] <= sum_wx;
         sy_mem[sum_addr] <= sum_wy;
         sz_mem[sum_addr] <= sum_wz;
      end
      sx_rd_ff <= sx_mem[sum_addr];
      sy_rd_ff <= sy_mem[sum_addr];
      sz_rd_ff <= sz_mem[sum_addr];
   end

   always_comb begin
      case (k_ff)
         2'd0:    corner = cmd_ff.index_a;
         2'd1:    corner = cmd_ff.index_b;
         default: corner = cmd_ff.index_c;
      endcase
      // cross product terms, one product a cycle
      case (step_ff)
         3'd0:    begin mul_a = n1_ff.y; mul_b = n2_ff.z; end
         3'd1:    begin mul_a = n1_ff.z; mul_b = n2_ff.y; end
         3'd2:    begin mul_a = n1_ff.z; mul_b = n2_ff.x; end
         3'd3:    begin mul_a = n1_ff.x; mul_b = n2_ff.z; end
         3'd4:    begin mul_a = n1_ff.x; mul_b = n2_ff.y; end
         default: begin mul_a = n1_ff.y; mul_b = n2_ff.x; end
      endcase
      prod     = mul_a * mul_b;
      cr_diff  = VEC_W'(prod_ff) - VEC_W'(prod);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      q_pop      = 1'b0;
      vtx_we     = 1'b0;
      vtx_addr   = cmd_ff.index_a;
      sum_we     = 1'b0;
      sum_addr   = cmd_ff.index_a;
      sum_wx     = '0;
      sum_wy     = '0;
      sum_wz     = '0;
      norm_start = 1'b0;
      norm_vec.x = VEC_W'(pcx_ff) - VEC_W'(pax_ff);
      norm_vec.y = VEC_W'(pcy_ff) - VEC_W'(pay_ff);
      norm_vec.z = VEC_W'(pcz_ff) - VEC_W'(paz_ff);
      unique case (state_ff)
         S_CLEAR: begin
            sum_we   = 1'b1;
            sum_addr = clr_ff;
         end
         S_IDLE: begin
            q_pop = q_valid;
         end
         S_LOAD: begin
            vtx_we = 1'b1;
            sum_we = 1'b1;
         end
         S_RWAIT: begin
            norm_start = 1'b1;
            norm_vec.x = VEC_W'(sx_rd_ff);
            norm_vec.y = VEC_W'(sy_rd_ff);
            norm_vec.z = VEC_W'(sz_rd_ff);
         end
         S_VB: vtx_addr = cmd_ff.index_b;
         S_VC: vtx_addr = cmd_ff.index_c;
         S_E1: norm_start = 1'b1;
         S_W1: begin
            norm_start = norm_done && norm_ok;
            norm_vec.x = VEC_W'(pbx_ff) - VEC_W'(pax_ff);
            norm_vec.y = VEC_W'(pby_ff) - VEC_W'(pay_ff);
            norm_vec.z = VEC_W'(pbz_ff) - VEC_W'(paz_ff);
         end
         S_CRN: begin
            norm_start = 1'b1;
            norm_vec   = cr_ff;
         end
         S_SA: sum_addr = corner;
         S_SB: begin
            sum_we   = 1'b1;
            sum_addr = corner;
            sum_wx   = sat_add(sx_rd_ff, fn_ff.x);
            sum_wy   = sat_add(sy_rd_ff, fn_ff.y);
            sum_wz   = sat_add(sz_rd_ff, fn_ff.z);
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a finished item reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IDX_W'(MAX_VERTICES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_valid) begin
                  case (q_head.kind)
                     K_LOAD:  state_ff <= S_LOAD;
                     K_TRI:   state_ff <= S_VA;
                     K_READ:  state_ff <= S_RSUM;
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_LOAD:  state_ff <= S_DONE;
            S_RSUM:  state_ff <= S_RWAIT;
            S_RWAIT: state_ff <= S_RNORM;
            S_RNORM: if (norm_done) state_ff <= S_DONE;
            S_VA:    state_ff <= S_VB;
            S_VB:    state_ff <= S_VC;
            S_VC:    state_ff <= S_VD;
            S_VD:    state_ff <= S_E1;
            S_E1:    state_ff <= S_W1;
            S_W1:    if (norm_done) state_ff <= norm_ok ? S_W2 : S_DONE;
            S_W2:    if (norm_done) state_ff <= norm_ok ? S_CR : S_DONE;
            S_CR:    if (step_ff == 3'd5) state_ff <= S_CRN;
            S_CRN:   state_ff <= S_W3;
            S_W3:    if (norm_done) state_ff <= norm_ok ? S_SA : S_DONE;
            S_SA:    state_ff <= S_SB;
            S_SB:    state_ff <= (k_ff == 2'd2) ? S_DONE : S_SA;
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            cmd_ff <= q_head;
            res_ff <= '{status: (q_head.kind == K_BAD) ? ST_RANGE : ST_OK,
                        normal_x: '0, normal_y: '0, normal_z: '0};
            k_ff    <= 2'd0;
            step_ff <= 3'd0;
         end
         S_RNORM: begin
            if (norm_done) begin
               if (norm_ok) begin
                  res_ff.normal_x <= norm_nrm.x;
                  res_ff.normal_y <= norm_nrm.y;
                  res_ff.normal_z <= norm_nrm.z;
               end else begin
                  res_ff.status <= ST_DEGEN;
               end
            end
         end
         S_VB: begin
            pax_ff <= vx_rd_ff;
            pay_ff <= vy_rd_ff;
            paz_ff <= vz_rd_ff;
         end
         S_VC: begin
            pbx_ff <= vx_rd_ff;
            pby_ff <= vy_rd_ff;
            pbz_ff <= vz_rd_ff;
         end
         S_VD: begin
            pcx_ff <= vx_rd_ff;
            pcy_ff <= vy_rd_ff;
            pcz_ff <= vz_rd_ff;
         end
         S_W1: begin
            if (norm_done) begin
               n1_ff <= norm_nrm;
               if (!norm_ok) res_ff.status <= ST_DEGEN;
            end
         end
         S_W2: begin
            if (norm_done) begin
               n2_ff <= norm_nrm;
               if (!norm_ok) res_ff.status <= ST_DEGEN;
            end
         end
         S_CR: begin
            step_ff <= step_ff + 3'd1;
            if (!step_ff[0]) begin
               prod_ff <= prod;
            end else begin
               case (step_ff[2:1])
                  2'd0:    cr_ff.x <= cr_diff;
                  2'd1:    cr_ff.y <= cr_diff;
                  default: cr_ff.z <= cr_diff;
               endcase
            end
         end
         S_W3: begin
            if (norm_done) begin
               fn_ff <= norm_nrm;
               if (!norm_ok) res_ff.status <= ST_DEGEN;
            end
         end
         S_SB: begin
            k_ff <= k_ff + 2'd1;
         end
         S_DONE: begin
            if (out_free) rsp_data_ff <= res_ff;
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   assign init_done = state_ff != S_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: test/testbench.sv
// Self-checking testbench of vertex_normal_accumulator: directed table, then random phases.
// Depends on vna_pkg and the block; expected results come from a predictor or typed rows.
module testbench;
   import vna_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int HANG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 250;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type e;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   // predictor state
   logic signed [POS_W-1:0] pos_x_mem [MAX_VERTICES];
   logic signed [POS_W-1:0] pos_y_mem [MAX_VERTICES];
   logic signed [POS_W-1:0] pos_z_mem [MAX_VERTICES];
   int                      acc_x [MAX_VERTICES];
   int                      acc_y [MAX_VERTICES];
   int                      acc_z [MAX_VERTICES];
   bit                      loaded [MAX_VERTICES];
   int                      vcount = 1024;

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      quiet_cycles = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   row_type plan [$];

   vertex_normal_accumulator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Scale to [2^29, 2^30), then divide by the integer length with rounding.
   function automatic bit to_unit(input longint c [3], output int n [3]);
      longint unsigned m [3];
      longint unsigned big, sq, len, q;
      big = 0;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
         m[k] = c[k] < 0 ? longint'(-c[k]) : longint'(c[k]);
         if (m[k] > big) big = m[k];
         n[k] = 0;
      end
      if (big == 0) return 1'b0;
      while (big >= (64'd1 << 30)) begin
         big >>= 1;
         for (int k = 0; k < 3; k++) m[k] >>= 1;
      end
      while (big < (64'd1 << 29)) begin
         big <<= 1;
         for (int k = 0; k < 3; k++) m[k] <<= 1;
      end
      for (int k = 0; k < 3; k++) sq += m[k] * m[k];
      len = int_sqrt(sq);
      for (int k = 0; k < 3; k++) begin
         q = ((m[k] << 14) + len / 2) / len;
         n[k] = c[k] < 0 ? -int'(q) : int'(q);
      end
      return 1'b1;
   endfunction

   function automatic int sat_sum(input int s, input int a);
      int r;
      r = s + a;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r;
   endfunction

   function automatic bit in_range(input int idx);
      int lim;
      lim = vcount < MAX_VERTICES ? vcount : MAX_VERTICES;
      return idx < lim;
   endfunction

   function automatic rsp_type predict_normal(input req_type r);
      rsp_type         o;
      longint          e1 [3], e2 [3], cr [3], s [3];
      int              n1 [3], n2 [3], fn [3];
      int              a, b, c;
      int              corner [3];
      o = '0;
      a = r.index_a;
      b = r.index_b;
      c = r.index_c;
      case (r.operation)
         OP_LOAD: begin
            if (!in_range(a)) o.status = ST_RANGE;
            else begin
               pos_x_mem[a] = r.pos_x;
               pos_y_mem[a] = r.pos_y;
               pos_z_mem[a] = r.pos_z;
               loaded[a] = 1'b1;
               acc_x[a] = 0;
               acc_y[a] = 0;
               acc_z[a] = 0;
            end
         end
         OP_TRI: begin
            if (!in_range(a) || !in_range(b) || !in_range(c)) o.status = ST_RANGE;
            else begin
               e1[0] = longint'(pos_x_mem[c]) - longint'(pos_x_mem[a]);
               e1[1] = longint'(pos_y_mem[c]) - longint'(pos_y_mem[a]);
               e1[2] = longint'(pos_z_mem[c]) - longint'(pos_z_mem[a]);
               e2[0] = longint'(pos_x_mem[b]) - longint'(pos_x_mem[a]);
               e2[1] = longint'(pos_y_mem[b]) - longint'(pos_y_mem[a]);
               e2[2] = longint'(pos_z_mem[b]) - longint'(pos_z_mem[a]);
               if (!to_unit(e1, n1) || !to_unit(e2, n2)) o.status = ST_DEGEN;
               else begin
                  cr[0] = longint'(n1[1]) * n2[2] - longint'(n1[2]) * n2[1];
                  cr[1] = longint'(n1[2]) * n2[0] - longint'(n1[0]) * n2[2];
                  cr[2] = longint'(n1[0]) * n2[1] - longint'(n1[1]) * n2[0];
                  if (!to_unit(cr, fn)) o.status = ST_DEGEN;
                  else begin
                     corner[0] = a;
                     corner[1] = b;
                     corner[2] = c;
                     for (int k = 0; k < 3; k++) begin
                        acc_x[corner[k]] = sat_sum(acc_x[corner[k]], fn[0]);
                        acc_y[corner[k]] = sat_sum(acc_y[corner[k]], fn[1]);
                        acc_z[corner[k]] = sat_sum(acc_z[corner[k]], fn[2]);
                     end
                  end
               end
            end
         end
         OP_READ: begin
            if (!in_range(a)) o.status = ST_RANGE;
            else begin
               s[0] = acc_x[a];
               s[1] = acc_y[a];
               s[2] = acc_z[a];
               if (!to_unit(s, n1)) o.status = ST_DEGEN;
               else begin
                  o.normal_x = NRM_W'(n1[0]);
                  o.normal_y = NRM_W'(n1[1]);
                  o.normal_z = NRM_W'(n1[2]);
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type item_of(input logic [1:0] op, input int a, input int b,
                                       input int c, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z);
      req_type r;
      r.operation = op;
      r.index_a = IDX_W'(a);
      r.index_b = IDX_W'(b);
      r.index_c = IDX_W'(c);
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      return r;
   endfunction

   function automatic rsp_type status_only(input logic [1:0] st);
      rsp_type o;
      o = '0;
      o.status = st;
      return o;
   endfunction

   // Hold valid across back-to-back items; drop it only for an idle gap.
   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type p;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = predict_normal(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
   endtask

   task automatic write_count(input int v);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CNT_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vcount = v;
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         default: return 32'($signed($urandom_range(8000000)) - 4000000);
      endcase
   endfunction

   function automatic req_type rand_item();
      int lim, pick, a, b, c, span;
      int pool [$];
      lim = vcount < MAX_VERTICES ? vcount : MAX_VERTICES;
      span = lim < 12 ? lim : 12;
      for (int i = 0; i < lim; i++) if (loaded[i]) pool.push_back(i);
      pick = $urandom_range(99);
      a = $urandom_range(1023);
      b = $urandom_range(1023);
      c = $urandom_range(1023);
      if (lim == 0 || pick < 8) begin
         // out-of-range index or noise
         if (lim < MAX_VERTICES && lim > 0) a = $urandom_range(1023, lim);
         return item_of(2'($urandom_range(3)), a, b, c, $urandom(), $urandom(), $urandom());
      end
      if (pick < 12) return item_of(OP_UNUSED, a, b, c, $urandom(), $urandom(), $urandom());
      if (pick < 40 || pool.size() == 0) begin
         if ($urandom_range(9) != 0) a = $urandom_range(span - 1);
         else a = $urandom_range(lim - 1);
         return item_of(OP_LOAD, a, b, c, rand_pos(), rand_pos(), rand_pos());
      end
      a = pool[$urandom_range(pool.size() - 1)];
      if (pick < 80) begin
         b = pool[$urandom_range(pool.size() - 1)];
         c = pool[$urandom_range(pool.size() - 1)];
         return item_of(OP_TRI, a, b, c, $urandom(), $urandom(), $urandom());
      end
      if ($urandom_range(3) == 0) a = $urandom_range(lim - 1);
      return item_of(OP_READ, a, b, c, $urandom(), $urandom(), $urandom());
   endfunction

   task automatic run_phase(input int cnt, input int idle, input int stall, input int n);
      write_count(cnt);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < n; i++) send_item(rand_item(), 1'b0, '0);
   endtask

   // receiver stalls, result checks and the hang watchdog
   always @(posedge clock) begin
      rsp_type want;
      rsp_ready <= $urandom_range(99) >= stall_pct;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected item: status %0d", rsp_data.status);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.normal_x !== want.normal_x) begin
                  $error("normal_x expected %0d got %0d", want.normal_x, rsp_data.normal_x);
                  errors++;
               end
               if (rsp_data.normal_y !== want.normal_y) begin
                  $error("normal_y expected %0d got %0d", want.normal_y, rsp_data.normal_y);
                  errors++;
               end
               if (rsp_data.normal_z !== want.normal_z) begin
                  $error("normal_z expected %0d got %0d", want.normal_z, rsp_data.normal_z);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      logic [31:0] pmax, pmin;
      rsp_type ok, degen;
      pmax = 32'h7FFF_FFFF;
      pmin = 32'h8000_0000;
      ok = status_only(ST_OK);
      degen = status_only(ST_DEGEN);
      for (int i = 0; i < MAX_VERTICES; i++) begin
         acc_x[i] = 0;
         acc_y[i] = 0;
         acc_z[i] = 0;
         loaded[i] = 1'b0;
      end
      plan.push_back('{item_of(OP_READ, 5, 0, 0, 0, 0, 0), 1'b1, degen});
      plan.push_back('{item_of(OP_UNUSED, 1023, 1023, 1023, pmin, pmax, pmin), 1'b1, ok});
      plan.push_back('{item_of(OP_LOAD, 0, 0, 0, 0, 0, 0), 1'b1, ok});
      plan.push_back('{item_of(OP_LOAD, 1, 0, 0, pmax, 0, 0), 1'b1, ok});
      plan.push_back('{item_of(OP_LOAD, 2, 0, 0, 0, pmax, 0), 1'b1, ok});
      plan.push_back('{item_of(OP_LOAD, 3, 0, 0, pmin, pmin, pmin), 1'b1, ok});
      plan.push_back('{item_of(OP_LOAD, 1023, 1023, 1023, 0, 0, pmax), 1'b1, ok});
      plan.push_back('{item_of(OP_LOAD, 4, 0, 0, 32'h0002_0000, 0, 0), 1'b1, ok});
      plan.push_back('{item_of(OP_TRI, 0, 1, 2, 0, 0, 0), 1'b0, ok});
      plan.push_back('{item_of(OP_TRI, 0, 2, 1, 0, 0, 0), 1'b0, ok});
      plan.push_back('{item_of(OP_TRI, 1023, 3, 1, 0, 0, 0), 1'b0, ok});
      plan.push_back('{item_of(OP_TRI, 0, 0, 1, 0, 0, 0), 1'b1, degen});
      plan.push_back('{item_of(OP_TRI, 0, 1, 4, 0, 0, 0), 1'b1, degen});
      plan.push_back('{item_of(OP_READ, 0, 0, 0, 0, 0, 0), 1'b0, ok});
      plan.push_back('{item_of(OP_READ, 1023, 0, 0, 0, 0, 0), 1'b0, ok});
      plan.push_back('{item_of(OP_READ, 3, 0, 0, 0, 0, 0), 1'b0, ok});
      plan.push_back('{item_of(OP_READ, 4, 0, 0, 0, 0, 0), 1'b1, degen});
      plan.push_back('{item_of(OP_LOAD, 0, 0, 0, pmax, pmin, pmax), 1'b1, ok});
      plan.push_back('{item_of(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, degen});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send_item(plan[i].r, plan[i].typed, plan[i].e);

      run_phase(1024, 0, 0, 200);
      run_phase(0, 49, 0, 40);
      run_phase(1, 0, 49, 60);
      // few vertices, so triangles keep adding to the same sums
      run_phase(3, 13, 13, 330);
      run_phase(2047, 49, 0, 180);
      run_phase(16, 0, 49, 170);
      run_phase(1024, 13, 13, 170);

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/vna_pkg.sv
hdl/vna_front.sv
hdl/vna_queue.sv
hdl/vna_norm.sv
hdl/vna_back.sv
hdl/vertex_normal_accumulator.sv
test/testbench.sv
